>>> design/sqss_pkg.sv
`default_nettype none

package sqss_pkg;

    localparam int MAX_STEPS_DEF = 16;
    localparam int QDEPTH        = 2;
    localparam int DIV_BITS      = 32;

    // stream word widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 3;

    // request kinds
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_SET  = 2'd1;
    localparam logic [1:0] REQ_ADJ  = 2'd2;
    localparam logic [1:0] REQ_NOP  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_STEP_COUNT   = 2'd0;
    localparam logic [1:0] CFG_SCALE_SELECT = 2'd1;
    localparam logic [1:0] CFG_VOICE_MODE   = 2'd2;
    localparam logic [1:0] CFG_TEMPO_BPM    = 2'd3;

    // voices
    localparam logic [1:0] VOICE_RING  = 2'd0;
    localparam logic [1:0] VOICE_GLIDE = 2'd1;
    localparam logic [1:0] VOICE_BONGO = 2'd2;

    // result actions
    localparam logic [2:0] ACT_NONE        = 3'd0;
    localparam logic [2:0] ACT_RING_HIT    = 3'd1;
    localparam logic [2:0] ACT_BONGO_HIT   = 3'd2;
    localparam logic [2:0] ACT_GLIDE_PITCH = 3'd3;
    localparam logic [2:0] ACT_GLIDE_MUTE  = 3'd4;

    localparam logic [4:0] STEP_COUNT_MIN = 5'd4;
    localparam logic [4:0] STEP_COUNT_RST = 5'd12;
    localparam logic [7:0] TEMPO_MIN      = 8'd70;
    localparam logic [7:0] TEMPO_MAX      = 8'd180;
    localparam logic [7:0] TEMPO_RST      = 8'd108;
    localparam logic [7:0] REST_LIMIT     = 8'd16;
    localparam logic [7:0] BONGO_MS       = 8'd90;
    localparam logic [6:0] ROOT_NOTE      = 7'd48;
    localparam logic [31:0] MS_PER_MIN    = 32'd60000;

    // degree quantizer: floor(((10*L - 153) * 4n + 2397) / 4794)
    localparam logic [11:0] DEG_OFFS    = 12'd153;
    localparam logic [16:0] DEG_BIAS    = 17'd2397;
    localparam logic [16:0] DEG_DIV     = 17'd4794;
    localparam logic [28:0] DEG_RECIP   = 29'd3499;   // floor(2^24 / 4794)
    localparam int          DEG_SHIFT   = 24;
    localparam logic [17:0] DIV5_MUL    = 18'd205;    // y*205 >> 10 == y/5 for y < 1024

    localparam int SEED_LEN = 12;
    localparam logic [7:0] SEED_LEVELS [SEED_LEN] = '{
        8'd115, 8'd153, 8'd191, 8'd140, 8'd0, 8'd166,
        8'd204, 8'd128, 8'd0, 8'd179, 8'd217, 8'd102
    };

    localparam logic [2:0] SCALE_LEN [4] = '{3'd5, 3'd7, 3'd6, 3'd6};
    localparam logic [3:0] SCALE_IV [4][7] = '{
        '{4'd0, 4'd3, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11},
        '{4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd0},
        '{4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10, 4'd0}
    };

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SET  = 2'd1,
        OP_ADJ  = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] idx;
        logic [7:0] value;
        logic [8:0] delta;
        logic       in_range;
    } job_t;

    typedef struct packed {
        logic [4:0] step_count;
        logic [1:0] scale_select;
        logic [1:0] voice_mode;
        logic [7:0] tempo_bpm;
    } cfg_t;

    typedef struct packed {
        logic [3:0] played_step;
        logic [2:0] action;
        logic [6:0] note;
        logic [2:0] volume;
        logic [7:0] duration_ms;
    } res_t;

    // 3 + floor(4*L/255)
    function automatic logic [2:0] hit_volume(input logic [7:0] lvl);
        logic [2:0] v;
        if (lvl == 8'd255)      v = 3'd7;
        else if (lvl >= 8'd192) v = 3'd6;
        else if (lvl >= 8'd128) v = 3'd5;
        else if (lvl >= 8'd64)  v = 3'd4;
        else                    v = 3'd3;
        return v;
    endfunction

    // 3 + floor(3*L/255)
    function automatic logic [2:0] glide_volume(input logic [7:0] lvl);
        logic [2:0] v;
        if (lvl == 8'd255)      v = 3'd6;
        else if (lvl >= 8'd170) v = 3'd5;
        else if (lvl >= 8'd85)  v = 3'd4;
        else                    v = 3'd3;
        return v;
    endfunction

    // degree is at most twice the scale length, so at most two octaves up
    function automatic logic [6:0] degree_note(input logic [1:0] sel, input logic [3:0] deg,
                                               input logic [2:0] len);
        logic [3:0] twice;
        logic [3:0] k;
        logic [6:0] offs;
        twice = {len, 1'b0};
        if (deg >= twice) begin
            k    = deg - twice;
            offs = 7'd24;
        end else if (deg >= {1'b0, len}) begin
            k    = deg - {1'b0, len};
            offs = 7'd12;
        end else begin
            k    = deg;
            offs = 7'd0;
        end
        return ROOT_NOTE + offs + {3'd0, SCALE_IV[sel][k[2:0]]};
    endfunction

endpackage

`default_nettype wire

>>> design/scale_quantized_step_sequencer.sv
// flow: set / adjust word ST_WRITE, ST_OUT; sounding tick ST_CALC, ST_MUL, ST_FIX, ST_NOTE, ST_OUT;
//   a rest or silent voice ST_CALC, ST_OUT; a ring voice also waits in ST_DUR for 60000/tempo on
//   the 32-step serial divider, and a tick that must rebuild tick_count mod ring length (first
//   tick after reset or after it changes) waits in ST_MOD first; a stalled m_tready holds ST_OUT
// throughput: one word at a time in the back end; a two-word queue keeps s_tready up meanwhile
// reset: synchronous, active low; registers to defaults, tick count zero, seed levels until written
`default_nettype none

module scale_quantized_step_sequencer #(
    parameter int MAX_STEPS = sqss_pkg::MAX_STEPS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [7:0]                      cfg_wdata,
    // request words
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [sqss_pkg::S_TDATA_W-1:0]  s_tdata,   // step_index, level_value, level_delta
    input  wire logic [sqss_pkg::S_TUSER_W-1:0]  s_tuser,   // req_type
    // result words
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [sqss_pkg::M_TDATA_W-1:0]       m_tdata,   // played_step, note, volume, duration_ms
    output logic [sqss_pkg::M_TUSER_W-1:0]       m_tuser    // action
);
    import sqss_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  q_valid;
    logic  q_pop;
    job_t  q_job;
    res_t  m_res;

    // configuration registers, to be written only while idle; the block itself does not enforce it
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_STEP_COUNT:   cfg_next.step_count   = cfg_wdata[4:0];
                CFG_SCALE_SELECT: cfg_next.scale_select = cfg_wdata[1:0];
                CFG_VOICE_MODE:   cfg_next.voice_mode   = cfg_wdata[1:0];
                CFG_TEMPO_BPM:    cfg_next.tempo_bpm    = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_count   <= STEP_COUNT_RST;
            cfg_reg.scale_select <= '0;
            cfg_reg.voice_mode   <= VOICE_RING;
            cfg_reg.tempo_bpm    <= TEMPO_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: decode request kind, queue the word
    sqss_front #(
        .MAX_STEPS (MAX_STEPS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_job    (q_job)
    );

    // back end: level store, quantizer, voice, output register
    sqss_back #(
        .MAX_STEPS (MAX_STEPS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_job    (q_job),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

    // result word packing, lowest field first, zero fill to whole bytes
    assign m_tdata = {2'b00, m_res.duration_ms, m_res.volume, m_res.note, m_res.played_step};
    assign m_tuser = m_res.action;

endmodule

`default_nettype wire

>>> design/sqss_front.sv
`default_nettype none

module sqss_front #(
    parameter int MAX_STEPS = sqss_pkg::MAX_STEPS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [sqss_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [sqss_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                  q_valid,
    input  wire logic                             q_pop,
    output sqss_pkg::job_t                        q_job
);
    import sqss_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    job_t                job_in;
    job_t                q_mem_reg [QDEPTH];
    logic [PW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PW:0]         count_reg, count_next;
    logic                push;

    // classify the incoming word
    always_comb begin
        job_in.idx      = s_tdata[3:0];
        job_in.value    = s_tdata[11:4];
        job_in.delta    = s_tdata[20:12];
        job_in.in_range = (32'(s_tdata[3:0]) < MAX_STEPS);
        unique case (s_tuser[1:0])
            REQ_TICK: job_in.op = OP_TICK;
            REQ_SET:  job_in.op = OP_SET;
            REQ_ADJ:  job_in.op = OP_ADJ;
            REQ_NOP:  job_in.op = OP_NOP;
        endcase
    end

    assign s_tready = (count_reg != (PW + 1)'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_job    = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop && q_valid) begin
            rd_ptr_next = (32'(rd_ptr_reg) == QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !(q_pop && q_valid)) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop && q_valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

`default_nettype wire

>>> design/sqss_div.sv
`default_nettype none

module sqss_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [sqss_pkg::DIV_BITS-1:0] dividend,
    input  wire logic [7:0]                    divisor,
    output logic                               busy,
    output logic                               done,
    output logic [sqss_pkg::DIV_BITS-1:0]      quot,
    output logic [7:0]                         rem
);
    import sqss_pkg::*;

    localparam int CW = $clog2(DIV_BITS);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [DIV_BITS-1:0] num_reg, num_next;
    logic [7:0]          rem_reg, rem_next;
    logic [7:0]          den_reg, den_next;
    logic [8:0]          trial;
    logic                ge;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, num_reg[DIV_BITS-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? 8'(trial - {1'b0, den_reg}) : trial[7:0];
            num_next = {num_reg[DIV_BITS-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (32'(cnt_reg) == DIV_BITS - 1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = num_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

>>> design/sqss_back.sv
`default_nettype none

module sqss_back #(
    parameter int MAX_STEPS = sqss_pkg::MAX_STEPS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire sqss_pkg::cfg_t cfg,
    input  wire logic           q_valid,
    output logic                q_pop,
    input  wire sqss_pkg::job_t q_job,
    output logic                m_valid,
    input  wire logic           m_ready,
    output sqss_pkg::res_t      m_res
);
    import sqss_pkg::*;

    localparam int AW = $clog2(MAX_STEPS);
    localparam int NW = $clog2(MAX_STEPS + 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MOD   = 9'b000000010,
        ST_WRITE = 9'b000000100,
        ST_CALC  = 9'b000001000,
        ST_MUL   = 9'b000010000,
        ST_FIX   = 9'b000100000,
        ST_NOTE  = 9'b001000000,
        ST_DUR   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t          state_reg, state_next;
    job_t            job_reg, job_next;
    logic [31:0]     tick_reg, tick_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic            pos_ok_reg, pos_ok_next;
    logic [NW-1:0]   pos_n_reg, pos_n_next;
    logic [7:0]      lvl_reg, lvl_next;
    logic [2:0]      len_reg, len_next;
    logic [16:0]     x_reg, x_next;
    logic [28:0]     prod_reg, prod_next;
    logic [3:0]      deg_reg, deg_next;
    res_t            res_reg, res_next;
    logic            m_valid_reg, m_valid_next;
    res_t            m_res_reg, m_res_next;

    // level store, with seed contour until written
    logic [7:0]      mem [MAX_STEPS];
    logic [MAX_STEPS-1:0] valid_reg;
    logic [7:0]      rd_data_reg;
    logic            rd_vld_reg;
    logic [7:0]      rd_seed_reg;
    logic [7:0]      seed_rd;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;
    logic [7:0]      level;

    logic [NW-1:0]   ring_len;
    logic [7:0]      tempo_sat;
    logic            out_free;

    logic                div_start;
    logic [DIV_BITS-1:0] div_dividend;
    logic [7:0]          div_divisor;
    logic                div_busy;
    logic                div_done;
    logic [DIV_BITS-1:0] div_quot;
    logic [7:0]          div_rem;

    logic [11:0]       lvl10;
    logic [2:0]        len_cur;
    logic signed [9:0] adj_sum;
    logic [7:0]        adj_lvl;
    logic [4:0]        q0;
    logic [16:0]       rchk;
    logic [4:0]        deg_raw;
    logic [9:0]        dur_q;
    logic [17:0]       dur_prod;

    sqss_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_comb begin
        if (cfg.step_count < STEP_COUNT_MIN) begin
            ring_len = NW'(STEP_COUNT_MIN);
        end else if (32'(cfg.step_count) > MAX_STEPS) begin
            ring_len = NW'(MAX_STEPS);
        end else begin
            ring_len = NW'(cfg.step_count);
        end
        if (cfg.tempo_bpm < TEMPO_MIN) begin
            tempo_sat = TEMPO_MIN;
        end else if (cfg.tempo_bpm > TEMPO_MAX) begin
            tempo_sat = TEMPO_MAX;
        end else begin
            tempo_sat = cfg.tempo_bpm;
        end
    end

    always_comb begin
        seed_rd = '0;
        for (int i = 0; i < MAX_STEPS; i++) begin
            if (rd_addr == AW'(i)) begin
                seed_rd = SEED_LEVELS[i % SEED_LEN];
            end
        end
    end

    assign level    = rd_vld_reg ? rd_data_reg : rd_seed_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign len_cur  = SCALE_LEN[cfg.scale_select];
    assign lvl10    = 12'({4'd0, level} * 12'd10) - DEG_OFFS;
    assign adj_sum  = $signed({2'b00, level}) + $signed({job_reg.delta[8], job_reg.delta});
    assign adj_lvl  = (adj_sum < 10'sd0) ? 8'd0 :
                      (adj_sum > 10'sd255) ? 8'd255 : adj_sum[7:0];
    assign q0       = prod_reg[DEG_SHIFT+4:DEG_SHIFT];
    assign rchk     = x_reg - 17'(17'(q0) * DEG_DIV);
    assign deg_raw  = (rchk >= DEG_DIV) ? q0 + 5'd1 : q0;
    assign dur_q    = {div_quot[9:2], 2'b00};
    assign dur_prod = 18'(dur_q) * DIV5_MUL;

    always_comb begin
        state_next   = state_reg;
        job_next     = job_reg;
        tick_next    = tick_reg;
        pos_next     = pos_reg;
        pos_ok_next  = pos_ok_reg;
        pos_n_next   = pos_n_reg;
        lvl_next     = lvl_reg;
        len_next     = len_reg;
        x_next       = x_reg;
        prod_next    = prod_reg;
        deg_next     = deg_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        q_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = tick_reg;
        div_divisor  = 8'(ring_len);
        rd_addr      = pos_reg;
        wr_en        = 1'b0;
        wr_addr      = AW'(job_reg.idx);
        wr_data      = adj_lvl;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    job_next = q_job;
                    unique case (q_job.op)
                        OP_TICK: begin
                            if (pos_ok_reg && pos_n_reg == ring_len) begin
                                state_next = ST_CALC;
                            end else begin
                                div_start   = 1'b1;
                                pos_ok_next = 1'b0;
                                pos_n_next  = ring_len;
                                state_next  = ST_MOD;
                            end
                        end
                        OP_SET, OP_ADJ: begin
                            rd_addr    = AW'(q_job.idx);
                            state_next = ST_WRITE;
                        end
                        OP_NOP: begin
                            res_next   = '0;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_MOD: begin
                rd_addr = AW'(div_rem);
                if (div_done) begin
                    pos_next    = AW'(div_rem);
                    pos_ok_next = 1'b1;
                    state_next  = ST_CALC;
                end
            end
            ST_WRITE: begin
                res_next             = '0;
                res_next.played_step = job_reg.idx;
                if (job_reg.in_range) begin
                    wr_en   = 1'b1;
                    wr_data = (job_reg.op == OP_SET) ? job_reg.value : adj_lvl;
                end
                state_next = ST_OUT;
            end
            ST_CALC: begin
                tick_next = tick_reg + 32'd1;
                if (tick_next == '0) begin
                    pos_next = '0;
                end else if (NW'(pos_reg) + NW'(1) == pos_n_reg) begin
                    pos_next = '0;
                end else begin
                    pos_next = pos_reg + AW'(1);
                end
                res_next             = '0;
                res_next.played_step = 4'(pos_reg);
                lvl_next             = level;
                len_next             = len_cur;
                x_next = 17'(17'(lvl10) * 17'({len_cur, 2'b00})) + DEG_BIAS;
                if (level < REST_LIMIT) begin
                    if (cfg.voice_mode == VOICE_GLIDE) begin
                        res_next.action = ACT_GLIDE_MUTE;
                    end
                    state_next = ST_OUT;
                end else if (cfg.voice_mode == VOICE_RING || cfg.voice_mode == VOICE_GLIDE
                             || cfg.voice_mode == VOICE_BONGO) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_MUL: begin
                prod_next  = 29'(x_reg) * DEG_RECIP;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                if (deg_raw > 5'({len_reg, 1'b0})) begin
                    deg_next = {len_reg, 1'b0};
                end else begin
                    deg_next = deg_raw[3:0];
                end
                state_next = ST_NOTE;
            end
            ST_NOTE: begin
                res_next.note = degree_note(cfg.scale_select, deg_reg, len_reg);
                case (cfg.voice_mode)
                    VOICE_RING: begin
                        res_next.action = ACT_RING_HIT;
                        res_next.volume = hit_volume(lvl_reg);
                        div_start       = 1'b1;
                        div_dividend    = MS_PER_MIN;
                        div_divisor     = tempo_sat;
                        state_next      = ST_DUR;
                    end
                    VOICE_BONGO: begin
                        res_next.action      = ACT_BONGO_HIT;
                        res_next.volume      = hit_volume(lvl_reg);
                        res_next.duration_ms = BONGO_MS;
                        state_next           = ST_OUT;
                    end
                    VOICE_GLIDE: begin
                        res_next.action = ACT_GLIDE_PITCH;
                        res_next.volume = glide_volume(lvl_reg);
                        state_next      = ST_OUT;
                    end
                    default: begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_DUR: begin
                if (div_done) begin
                    res_next.duration_ms = dur_prod[17:10];
                    state_next           = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tick_reg    <= '0;
            pos_ok_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            tick_reg    <= tick_next;
            pos_ok_reg  <= pos_ok_next;
            m_valid_reg <= m_valid_next;
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        job_reg   <= job_next;
        pos_reg   <= pos_next;
        pos_n_reg <= pos_n_next;
        lvl_reg   <= lvl_next;
        len_reg   <= len_next;
        x_reg     <= x_next;
        prod_reg  <= prod_next;
        deg_reg   <= deg_next;
        res_reg   <= res_next;
        m_res_reg <= m_res_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= valid_reg[rd_addr];
        rd_seed_reg <= seed_rd;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    a_pos_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_ok_reg |-> (NW'(pos_reg) < pos_n_reg))
        else $error("cached step position outside ring");

    a_tick_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) |=> (tick_reg == $past(tick_reg) + 32'd1))
        else $error("tick count did not advance once");

    a_deg_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NOTE) |-> (deg_reg <= {len_reg, 1'b0}))
        else $error("scale degree above two octaves");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !div_busy)
        else $error("divider running with no item at work");

endmodule

`default_nettype wire

>>> verif/scale_quantized_step_sequencer_tb.sv
`timescale 1ns / 1ps

module scale_quantized_step_sequencer_tb;
    import sqss_pkg::*;

    // voice code with no sound, not named in the package
    localparam logic [1:0] VOICE_MUTE = 2'd3;

    // one request word as the sender sees it
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] idx;
        logic [7:0] lvl;
        logic [8:0] delta;
    } req_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [7:0] cfg_wdata = 8'd0;
    logic s_tvalid = 1'b0;
    wire s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    wire m_tvalid;
    logic m_tready = 1'b0;
    wire [M_TDATA_W-1:0] m_tdata;
    wire [M_TUSER_W-1:0] m_tuser;

    scale_quantized_step_sequencer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // step_index, level_value, level_delta
        .s_tuser   (s_tuser),   // req_type
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // played_step, note, volume, duration_ms
        .m_tuser   (m_tuser)    // action
    );

    always #2 aclk = ~aclk;

    // own copy of the sequencer state and registers
    logic [7:0] step_lvl [16];
    logic [31:0] tick_total;
    logic [7:0] cfg_steps, cfg_scale, cfg_voice, cfg_tempo;

    // scale tables and the power-up contour
    int scale_len [4] = '{5, 7, 6, 6};
    int scale_steps [4][7] = '{
        '{0, 3, 5, 7, 10, 0, 0},
        '{0, 2, 4, 5, 7, 9, 11},
        '{0, 2, 4, 6, 8, 10, 0},
        '{0, 3, 5, 6, 7, 10, 0}
    };
    logic [7:0] seed_contour [12] = '{
        8'd115, 8'd153, 8'd191, 8'd140, 8'd0, 8'd166,
        8'd204, 8'd128, 8'd0, 8'd179, 8'd217, 8'd102
    };

    // register settings at and beyond the edges of their ranges
    logic [7:0] edge_steps [6] = '{8'd4, 8'd16, 8'd0, 8'd31, 8'd5, 8'd16};
    logic [7:0] edge_scale [6] = '{8'd3, 8'd2, 8'd1, 8'd0, 8'd3, 8'd1};
    logic [7:0] edge_voice [6] = '{8'd1, 8'd2, 8'd0, 8'd0, 8'd3, 8'd0};
    logic [7:0] edge_tempo [6] = '{8'd180, 8'd70, 8'd0, 8'd255, 8'd69, 8'd181};

    req_word_t req_backlog [$];    // words waiting for the driver
    res_t due_notes [$];           // predicted result words, oldest first
    req_word_t cur_req;            // word currently on the s_ bus
    bit word_taken = 1'b0;         // s_ handshake seen at the last rising edge
    int mismatches = 0;

    // sender and receiver pacing
    int burst_left = 0;
    int gap_left = 0;
    bit tx_dense = 1'b0;
    bit hold_start = 1'b0;
    int hold_left = 0;
    int rx_run = 0;
    bit rx_state = 1'b1;

    // one request through the sequencer: update state, return the result word
    function automatic res_t sequence_step(input req_word_t w);
        res_t r;
        int ring_n, pos, lvl, n, deg, tempo, d, sum;
        r = '0;
        case (w.kind)
            REQ_TICK: begin
                ring_n = (cfg_steps[4:0] < 4) ? 4 : ((cfg_steps[4:0] > 16) ? 16 : cfg_steps[4:0]);
                pos = int'(tick_total % ring_n);
                lvl = step_lvl[pos];
                r.played_step = pos[3:0];
                tick_total = tick_total + 1;
                if (lvl < 16) begin
                    // rest: only the glide voice reports it
                    if (cfg_voice[1:0] == VOICE_GLIDE) r.action = ACT_GLIDE_MUTE;
                end else if (cfg_voice[1:0] != VOICE_MUTE) begin
                    n = scale_len[cfg_scale[1:0]];
                    deg = ((10 * lvl - 153) * 4 * n + 2397) / 4794;
                    if (deg > 2 * n) deg = 2 * n;
                    r.note = 7'(48 + 12 * (deg / n) + scale_steps[cfg_scale[1:0]][deg % n]);
                    case (cfg_voice[1:0])
                        VOICE_RING: begin
                            tempo = cfg_tempo;
                            if (tempo < 70) tempo = 70;
                            if (tempo > 180) tempo = 180;
                            r.action = ACT_RING_HIT;
                            r.volume = 3'(3 + (4 * lvl) / 255);
                            r.duration_ms = 8'(((60000 / tempo) / 4 * 4) / 5);
                        end
                        VOICE_BONGO: begin
                            r.action = ACT_BONGO_HIT;
                            r.volume = 3'(3 + (4 * lvl) / 255);
                            r.duration_ms = 8'd90;
                        end
                        default: begin
                            r.action = ACT_GLIDE_PITCH;
                            r.volume = 3'(3 + (3 * lvl) / 255);
                        end
                    endcase
                end
            end
            REQ_SET: begin
                r.played_step = w.idx;
                step_lvl[w.idx] = w.lvl;
            end
            REQ_ADJ: begin
                r.played_step = w.idx;
                d = $signed(w.delta);
                sum = int'(step_lvl[w.idx]) + d;
                if (sum < 0) sum = 0;
                if (sum > 255) sum = 255;
                step_lvl[w.idx] = sum[7:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic req_word_t random_request();
        req_word_t w;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) w.kind = REQ_TICK;
        else if (pick < 72) w.kind = REQ_SET;
        else if (pick < 95) w.kind = REQ_ADJ;
        else w.kind = REQ_NOP;
        w.idx = 4'($urandom_range(0, 15));
        w.delta = 9'($urandom_range(0, 511));
        // lean on the rest threshold and full scale now and then
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
                0: w.lvl = 8'd0;
                1: w.lvl = 8'd15;
                2: w.lvl = 8'd16;
                3: w.lvl = 8'd17;
                4: w.lvl = 8'd254;
                default: w.lvl = 8'd255;
            endcase
        end else begin
            w.lvl = 8'($urandom_range(0, 255));
        end
        return w;
    endfunction

    function automatic req_word_t make_req(input logic [1:0] kind, input int idx,
                                           input int lvl, input int delta);
        req_word_t w;
        w.kind = kind;
        w.idx = 4'(idx);
        w.lvl = 8'(lvl);
        w.delta = 9'(delta);
        return w;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // register write while the block is idle, mirror follows at once
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_STEP_COUNT:   cfg_steps = val;
            CFG_SCALE_SELECT: cfg_scale = val;
            CFG_VOICE_MODE:   cfg_voice = val;
            default:          cfg_tempo = val;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // nothing queued, nothing on the bus, nothing still due
    task automatic wait_drained();
        do begin
            @(posedge aclk);
            #1;
        end while (req_backlog.size() != 0 || s_tvalid || due_notes.size() != 0);
    endtask

    // driver: next word at the falling edge once the current one is gone
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            word_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
                cur_req = req_backlog.pop_front();
                s_tdata <= {3'b000, cur_req.delta, cur_req.lvl, cur_req.idx};
                s_tuser <= cur_req.kind;
                s_tvalid <= 1'b1;
                if (burst_left == 0) burst_left = $urandom_range(1, 24);
                burst_left--;
                // end of burst, unless sending dense: pick a gap, short mostly, long now and then
                if (burst_left == 0 && !tx_dense) begin
                    if ($urandom_range(0, 4) == 0) gap_left = $urandom_range(10, 90);
                    else gap_left = $urandom_range(0, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern, plus a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_start) begin
            hold_start = 1'b0;
            hold_left = 400;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_run == 0) begin
                rx_state = ($urandom_range(0, 99) < 65);
                if (rx_state && $urandom_range(0, 9) == 0) rx_run = $urandom_range(100, 200);
                else if (rx_state) rx_run = $urandom_range(1, 30);
                else rx_run = $urandom_range(1, 10);
            end
            rx_run--;
            m_tready <= rx_state;
        end
    end

    // monitor: check result words, predict for accepted request words
    always @(posedge aclk) begin
        res_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (due_notes.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h/%h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    want = due_notes.pop_front();
                    check_field("played_step", want.played_step, m_tdata[3:0]);
                    check_field("action", want.action, m_tuser);
                    check_field("note", want.note, m_tdata[10:4]);
                    check_field("volume", want.volume, m_tdata[13:11]);
                    check_field("duration_ms", want.duration_ms, m_tdata[21:14]);
                end
            end
            if (s_tvalid && s_tready) begin
                due_notes.push_back(sequence_step(cur_req));
                word_taken = 1'b1;
            end
        end
    end

    // stimulus sequence
    initial begin
        int p, k, n_items;
        for (k = 0; k < 16; k++) step_lvl[k] = seed_contour[k % 12];
        tick_total = 0;
        cfg_steps = 8'd12;
        cfg_scale = 8'd0;
        cfg_voice = 8'd0;
        cfg_tempo = 8'd108;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        #1;

        // reset settings: sweep the seed contour once, rests included
        for (k = 0; k < 12; k++) req_backlog.push_back(make_req(REQ_TICK, 0, 0, 0));
        // full scale, zero, just under, at and just over the rest threshold,
        // an adjust up to full scale, saturation at zero, the top step and the no-op request code
        req_backlog.push_back(make_req(REQ_SET, 0, 255, 0));
        req_backlog.push_back(make_req(REQ_SET, 1, 0, 9'h1ff));
        req_backlog.push_back(make_req(REQ_SET, 2, 15, 0));
        req_backlog.push_back(make_req(REQ_SET, 3, 16, 0));
        req_backlog.push_back(make_req(REQ_ADJ, 3, 0, 1));
        req_backlog.push_back(make_req(REQ_ADJ, 4, 0, 255));
        req_backlog.push_back(make_req(REQ_ADJ, 5, 0, -255));
        req_backlog.push_back(make_req(REQ_ADJ, 15, 255, -1));
        req_backlog.push_back(make_req(REQ_NOP, 15, 255, 9'h100));
        for (k = 0; k < 6; k++) req_backlog.push_back(make_req(REQ_TICK, 15, 255, 9'h1ff));
        wait_drained();

        for (p = 0; p < 20; p++) begin
            if (p < 6) begin
                write_reg(CFG_STEP_COUNT, edge_steps[p]);
                write_reg(CFG_SCALE_SELECT, edge_scale[p]);
                write_reg(CFG_VOICE_MODE, edge_voice[p]);
                write_reg(CFG_TEMPO_BPM, edge_tempo[p]);
                n_items = 40;
            end else begin
                write_reg(CFG_STEP_COUNT, ($urandom_range(0, 9) == 0) ?
                          8'($urandom_range(0, 255)) : 8'($urandom_range(4, 16)));
                write_reg(CFG_SCALE_SELECT, ($urandom_range(0, 7) == 0) ?
                          8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3)));
                write_reg(CFG_VOICE_MODE, ($urandom_range(0, 7) == 0) ?
                          8'(VOICE_MUTE) : 8'($urandom_range(0, 2)));
                write_reg(CFG_TEMPO_BPM, ($urandom_range(0, 7) == 0) ?
                          8'($urandom_range(0, 255)) : 8'($urandom_range(70, 180)));
                n_items = 100;
            end
            // one phase with a long receiver hold-off and a sender that keeps pushing
            if (p == 10) begin
                tx_dense = 1'b1;
                hold_start = 1'b1;
            end else begin
                tx_dense = ($urandom_range(0, 3) == 0);
            end
            for (k = 0; k < n_items; k++) req_backlog.push_back(random_request());
            wait_drained();
        end

        // allow for any stray word after the last one due
        repeat (150) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
